// ----- rtl/core/gte_pkg.sv -----
// Shared constants, types and latencies of the geodetic to ECEF converter.
// Depends on nothing; gte_term, gte_trig, gte_radius and geodetic_to_ecef use it.
package gte_pkg;

    localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

    // Angle units of 1e-7 degree.
    localparam logic [31:0] FULL_TURN_E7     = 32'd3600000000;
    localparam logic [31:0] THREE_QUART_E7   = 32'd2700000000;
    localparam logic [31:0] HALF_TURN_E7     = 32'd1800000000;
    localparam logic [31:0] QUARTER_E7       = 32'd900000000;
    localparam logic [31:0] EIGHTH_E7        = 32'd450000000;

    // pi / 1.8e9 in Q93.
    localparam logic [127:0] PI_Q124 = 128'h3243F6A8885A308D313198A2E0370734;
    localparam logic [127:0] HALF_TURN_W = 128'd1800000000;
    localparam logic [63:0]  K_Q93 = 64'((PI_Q124 / HALF_TURN_W) >> 31);

    // WGS84 flattening terms in Q62.
    localparam logic [127:0] FLAT_NUM    = 128'd1000000000 << 62;
    localparam logic [127:0] INV_FLAT_E9 = 128'd298257223563;
    localparam logic [63:0]  F_Q62   = 64'(FLAT_NUM / INV_FLAT_E9);
    localparam logic [127:0] F_SQ    = 128'(F_Q62) * 128'(F_Q62);
    localparam logic [63:0]  E2_Q62  = (F_Q62 << 1) - 64'(F_SQ >> 62);
    localparam logic [63:0]  OMF_Q62 = ONE_Q62 - F_Q62;
    localparam logic [127:0] OMF_SQ  = 128'(OMF_Q62) * 128'(OMF_Q62);
    localparam logic [63:0]  BSQ_Q62 = 64'(OMF_SQ >> 62);

    // Semi-major axis in mm, scaled for a Q20 radius after division by a Q62 root.
    localparam logic [127:0] SEMI_MAJOR_MM = 128'd6378137000;
    localparam logic [127:0] DIV_NUM = SEMI_MAJOR_MM << 82;

    localparam int TAYLOR_TERMS = 13;
    localparam int SQ_STEPS     = 64;
    localparam int DIV_STEPS    = 54;

    localparam int LAT_MUL    = 2;
    localparam int LAT_TERM   = 2 * LAT_MUL + 2;
    localparam int LAT_TRIG   = 3 + 2 * LAT_MUL + TAYLOR_TERMS * LAT_TERM + 1;
    localparam int LAT_RADIUS = 2 * LAT_MUL + 1 + SQ_STEPS + DIV_STEPS;

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } t_quad;

    // Running state of the sine and cosine series.
    typedef struct packed {
        logic [63:0] t2;
        logic [63:0] ct;
        logic [63:0] st;
        logic [63:0] cs;
        logic [63:0] ss;
    } t_series;

    typedef struct packed {
        logic [63:0] sin_mag;
        logic        sin_neg;
        logic [63:0] cos_mag;
        logic        cos_neg;
    } t_trig;

endpackage

// ----- rtl/core/gte_mul64.sv -----
// Two-stage 64 x 64 unsigned multiplier built from four 32 x 32 partial products.
// Depends on nothing.
module gte_mul64 (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic [127:0]  o_p
);

    logic [63:0]  r_p0, r_p1, r_p2, r_p3;
    logic [127:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= i_a[31:0]  * i_b[31:0];
            r_p1 <= i_a[31:0]  * i_b[63:32];
            r_p2 <= i_a[63:32] * i_b[31:0];
            r_p3 <= i_a[63:32] * i_b[63:32];
            r_p  <= {r_p3, r_p0} + {32'd0, r_p1, 32'd0} + {32'd0, r_p2, 32'd0};
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/core/gte_delay.sv -----
// Enabled shift line that holds side data level with the arithmetic stages.
// Depends on nothing.
module gte_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [W-1:0]  i_d,
    output logic [W-1:0]  o_d
);

    logic [W-1:0] r_d [0:N-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_d[k] <= r_d[k-1];
            end
        end
    end

    assign o_d = r_d[N-1];

endmodule

// ----- rtl/core/gte_term.sv -----
// One Taylor term cell: next sine and cosine terms and their running sums.
// Depends on gte_pkg, gte_mul64 and gte_delay.
module gte_term #(
    parameter int K = 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  gte_pkg::t_series  i_s,
    output gte_pkg::t_series  o_s
);

    localparam int DC = (2 * K - 1) * (2 * K);
    localparam int DS = (2 * K) * (2 * K + 1);
    localparam logic [63:0] MC = 64'((128'd1 << 64) / 128'(DC));
    localparam logic [63:0] MS = 64'((128'd1 << 64) / 128'(DS));
    localparam logic SUBTRACT = K[0];

    logic [127:0] p_c, p_s, p_rc, p_rs;
    logic [63:0]  y_c, y_s, y_c_d, y_s_d, q0_c, q0_s, rem_c, rem_s;
    logic [63:0]  n_qc, n_qs, r_qc, r_qs, r_ct, r_st, r_cs, r_ss;
    logic [63:0]  cs_d, ss_d, t2_d;

    gte_mul64 u_mul_c (.i_clk(i_clk), .i_en(i_en), .i_a(i_s.ct), .i_b(i_s.t2), .o_p(p_c));
    gte_mul64 u_mul_s (.i_clk(i_clk), .i_en(i_en), .i_a(i_s.st), .i_b(i_s.t2), .o_p(p_s));

    assign y_c = p_c[125:62];
    assign y_s = p_s[125:62];

    // Divide by the constant: reciprocal estimate, then one correction.
    gte_mul64 u_rcp_c (.i_clk(i_clk), .i_en(i_en), .i_a(y_c), .i_b(MC), .o_p(p_rc));
    gte_mul64 u_rcp_s (.i_clk(i_clk), .i_en(i_en), .i_a(y_s), .i_b(MS), .o_p(p_rs));

    gte_delay #(.W(128), .N(gte_pkg::LAT_MUL)) u_dly_y (
        .i_clk(i_clk), .i_en(i_en), .i_d({y_c, y_s}), .o_d({y_c_d, y_s_d})
    );

    assign q0_c = p_rc[127:64];
    assign q0_s = p_rs[127:64];

    always_comb begin
        rem_c = y_c_d - q0_c * 64'(DC);
        rem_s = y_s_d - q0_s * 64'(DS);
        n_qc  = q0_c + 64'(rem_c >= 64'(DC));
        n_qs  = q0_s + 64'(rem_s >= 64'(DS));
    end

    gte_delay #(.W(128), .N(2 * gte_pkg::LAT_MUL + 1)) u_dly_sum (
        .i_clk(i_clk), .i_en(i_en), .i_d({i_s.cs, i_s.ss}), .o_d({cs_d, ss_d})
    );

    gte_delay #(.W(64), .N(gte_pkg::LAT_TERM)) u_dly_t2 (
        .i_clk(i_clk), .i_en(i_en), .i_d(i_s.t2), .o_d(t2_d)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qc <= n_qc;
            r_qs <= n_qs;
            r_ct <= r_qc;
            r_st <= r_qs;
            r_cs <= SUBTRACT ? cs_d - r_qc : cs_d + r_qc;
            r_ss <= SUBTRACT ? ss_d - r_qs : ss_d + r_qs;
        end
    end

    assign o_s.t2 = t2_d;
    assign o_s.ct = r_ct;
    assign o_s.st = r_st;
    assign o_s.cs = r_cs;
    assign o_s.ss = r_ss;

endmodule

// ----- rtl/core/gte_trig.sv -----
// Sine and cosine of an angle in 1e-7 degree: reduction, octant fold, term chain.
// Depends on gte_pkg, gte_mul64, gte_delay and gte_term.
module gte_trig (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [31:0]  i_ang,
    output gte_pkg::t_trig      o_trig
);

    localparam int NT = gte_pkg::TAYLOR_TERMS;

    logic [31:0]    n_m, r_m;
    gte_pkg::t_quad n_q, r_q, r_q3, q_d;
    logic [29:0]    n_r, r_r;
    logic [28:0]    n_rr, r_rr;
    logic           n_swap, r_swap, swap_d;
    logic [127:0]   p_t, p_t2;
    logic [63:0]    t, t_d, s0, c0;
    logic [2:0]     side_d;
    gte_pkg::t_series chain [0:NT];
    gte_pkg::t_trig   n_out, r_out;

    always_comb begin
        n_m = i_ang[31] ? 32'(i_ang) + gte_pkg::FULL_TURN_E7 : 32'(i_ang);
    end

    always_comb begin
        if (r_m < gte_pkg::QUARTER_E7) begin
            n_q = gte_pkg::QUAD_I;
            n_r = 30'(r_m);
        end else if (r_m < gte_pkg::HALF_TURN_E7) begin
            n_q = gte_pkg::QUAD_II;
            n_r = 30'(r_m - gte_pkg::QUARTER_E7);
        end else if (r_m < gte_pkg::THREE_QUART_E7) begin
            n_q = gte_pkg::QUAD_III;
            n_r = 30'(r_m - gte_pkg::HALF_TURN_E7);
        end else begin
            n_q = gte_pkg::QUAD_IV;
            n_r = 30'(r_m - gte_pkg::THREE_QUART_E7);
        end
    end

    always_comb begin
        n_swap = 32'(r_r) > gte_pkg::EIGHTH_E7;
        n_rr   = n_swap ? 29'(gte_pkg::QUARTER_E7 - 32'(r_r)) : 29'(r_r);
    end

    gte_mul64 u_mul_rad (
        .i_clk(i_clk), .i_en(i_en), .i_a(64'(r_rr)), .i_b(gte_pkg::K_Q93), .o_p(p_t)
    );
    assign t = p_t[94:31];

    gte_mul64 u_mul_sq (.i_clk(i_clk), .i_en(i_en), .i_a(t), .i_b(t), .o_p(p_t2));

    gte_delay #(.W(64), .N(gte_pkg::LAT_MUL)) u_dly_t (
        .i_clk(i_clk), .i_en(i_en), .i_d(t), .o_d(t_d)
    );

    assign chain[0].t2 = p_t2[125:62];
    assign chain[0].ct = gte_pkg::ONE_Q62;
    assign chain[0].st = t_d;
    assign chain[0].cs = gte_pkg::ONE_Q62;
    assign chain[0].ss = t_d;

    for (genvar j = 0; j < NT; j++) begin : g_term
        gte_term #(.K(j + 1)) u_term (
            .i_clk(i_clk), .i_en(i_en), .i_s(chain[j]), .o_s(chain[j+1])
        );
    end

    gte_delay #(.W(3), .N(2 * gte_pkg::LAT_MUL + NT * gte_pkg::LAT_TERM)) u_dly_side (
        .i_clk(i_clk), .i_en(i_en), .i_d({r_swap, r_q3}), .o_d(side_d)
    );
    assign swap_d = side_d[2];
    assign q_d    = gte_pkg::t_quad'(side_d[1:0]);

    always_comb begin
        s0 = swap_d ? chain[NT].cs : chain[NT].ss;
        c0 = swap_d ? chain[NT].ss : chain[NT].cs;
        case (q_d)
            gte_pkg::QUAD_I: begin
                n_out = '{sin_mag: s0, sin_neg: 1'b0, cos_mag: c0, cos_neg: 1'b0};
            end
            gte_pkg::QUAD_II: begin
                n_out = '{sin_mag: c0, sin_neg: 1'b0, cos_mag: s0, cos_neg: 1'b1};
            end
            gte_pkg::QUAD_III: begin
                n_out = '{sin_mag: s0, sin_neg: 1'b1, cos_mag: c0, cos_neg: 1'b1};
            end
            default: begin
                n_out = '{sin_mag: c0, sin_neg: 1'b1, cos_mag: s0, cos_neg: 1'b0};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= n_m;
            r_q    <= n_q;
            r_r    <= n_r;
            r_rr   <= n_rr;
            r_swap <= n_swap;
            r_q3   <= r_q;
            r_out  <= n_out;
        end
    end

    assign o_trig = r_out;

endmodule

// ----- rtl/core/gte_radius.sv -----
// Prime-vertical radius in Q20 mm from sin(lat): 1 - e^2 sin^2, root cells, divider cells.
// Depends on gte_pkg and gte_mul64.
module gte_radius (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [63:0]  i_sin,
    output logic [63:0]  o_n20
);

    localparam int SQ = gte_pkg::SQ_STEPS;
    localparam int DV = gte_pkg::DIV_STEPS;

    logic [127:0] p_ss, p_e;
    logic [63:0]  r_w;

    gte_mul64 u_mul_ss (.i_clk(i_clk), .i_en(i_en), .i_a(i_sin), .i_b(i_sin), .o_p(p_ss));
    gte_mul64 u_mul_e2 (
        .i_clk(i_clk), .i_en(i_en), .i_a(p_ss[125:62]), .i_b(gte_pkg::E2_Q62), .o_p(p_e)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w <= gte_pkg::ONE_Q62 - p_e[125:62];
        end
    end

    // Root of w << 62, one result bit per cell.
    logic [65:0] r_sq_rem  [0:SQ-1];
    logic [63:0] r_sq_root [0:SQ-1];
    logic [63:0] r_sq_w    [0:SQ-1];

    for (genvar j = 0; j < SQ; j++) begin : g_sq
        localparam int XB = 2 * (SQ - 1 - j) + 1;
        logic [65:0]  rem_in, rem_sh, trial;
        logic [63:0]  root_in, w_in;
        logic [127:0] x;
        logic         ge;
        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign w_in    = r_w;
        end else begin : g_next
            assign rem_in  = r_sq_rem[j-1];
            assign root_in = r_sq_root[j-1];
            assign w_in    = r_sq_w[j-1];
        end
        always_comb begin
            x      = {2'b00, w_in, 62'd0};
            rem_sh = {rem_in[63:0], x[XB -: 2]};
            trial  = {root_in, 2'b01};
            ge     = rem_sh >= trial;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_rem[j]  <= ge ? rem_sh - trial : rem_sh;
                r_sq_root[j] <= {root_in[62:0], ge};
                r_sq_w[j]    <= w_in;
            end
        end
    end

    // Constant numerator over the root, one quotient bit per cell.
    logic [63:0]   r_dv_rem  [0:DV-1];
    logic [63:0]   r_dv_root [0:DV-1];
    logic [DV-1:0] r_dv_q    [0:DV-1];

    for (genvar j = 0; j < DV; j++) begin : g_dv
        localparam logic NB = gte_pkg::DIV_NUM[DV - 1 - j];
        logic [63:0]   rem_in, root_in;
        logic [DV-1:0] q_in;
        logic [64:0]   rem_sh;
        logic          ge;
        if (j == 0) begin : g_first
            assign rem_in  = 64'(gte_pkg::DIV_NUM >> DV);
            assign root_in = r_sq_root[SQ-1];
            assign q_in    = '0;
        end else begin : g_next
            assign rem_in  = r_dv_rem[j-1];
            assign root_in = r_dv_root[j-1];
            assign q_in    = r_dv_q[j-1];
        end
        always_comb begin
            rem_sh = {rem_in, NB};
            ge     = rem_sh >= {1'b0, root_in};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_rem[j]  <= ge ? 64'(rem_sh - {1'b0, root_in}) : 64'(rem_sh);
                r_dv_root[j] <= root_in;
                r_dv_q[j]    <= {q_in[DV-2:0], ge};
            end
        end
    end

    assign o_n20 = 64'(r_dv_q[DV-1]);

endmodule

// ----- rtl/core/geodetic_to_ecef.sv -----
// Top level of the WGS84 geodetic to ECEF converter.
// Depends on gte_pkg, gte_trig, gte_radius, gte_mul64 and gte_delay.
//
// Usage:
//   Input channel: i_valid / o_stall with latitude and longitude in 1e-7 degree
//   and height above the ellipsoid in mm. A request is taken at a rising edge
//   with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with x, y and z in mm. A result leaves at
//   a rising edge with o_valid high and i_stall low.
//   Throughput: one request per cycle while o_stall is low. The depth is set by
//   the 13-cell Taylor series chain, the 64-cell root and the 54-cell divider.
//   Every request gives exactly one result, in order.
//   Stall: the whole pipeline advances on one enable. A two-entry output queue
//   sits behind it, so requests keep flowing while one result waits; once both
//   entries are full, o_stall rises and the pipeline holds until a result
//   is taken.
//   Reset: synchronous, active low; it drops every request in flight and
//   empties the output queue. No clearing pass is needed afterwards.
module geodetic_to_ecef (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [30:0]  i_lat_e7,
    input  logic signed [31:0]  i_lon_e7,
    input  logic signed [27:0]  i_alt_mm,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [33:0]  o_ecef_x_mm,
    output logic signed [33:0]  o_ecef_y_mm,
    output logic signed [33:0]  o_ecef_z_mm
);

    localparam int LT       = gte_pkg::LAT_TRIG;
    localparam int LR       = gte_pkg::LAT_RADIUS;
    localparam int LAT_PIPE = LT + LR + 1 + 2 * gte_pkg::LAT_MUL;

    logic           en;
    logic           push, pop;
    logic [LAT_PIPE-1:0] r_vld;
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt, n_cnt;

    // Pipeline enable: advance while the output queue has a free entry.
    assign en      = (r_cnt != 2'd2);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT_PIPE-2:0], i_valid};
        end
    end

    // Sine and cosine of both angles, in parallel.
    gte_pkg::t_trig lat_tr, lon_tr;

    gte_trig u_trig_lat (
        .i_clk(i_clk), .i_en(en), .i_ang({i_lat_e7[30], i_lat_e7}), .o_trig(lat_tr)
    );
    gte_trig u_trig_lon (
        .i_clk(i_clk), .i_en(en), .i_ang(i_lon_e7), .o_trig(lon_tr)
    );

    // Prime-vertical radius from sin(lat).
    logic [63:0] n20;
    gte_radius u_radius (.i_clk(i_clk), .i_en(en), .i_sin(lat_tr.sin_mag), .o_n20(n20));

    // Hold altitude and trig values level with the radius.
    logic [27:0] alt_d;
    logic [63:0] alt20, alt20_d;
    gte_delay #(.W(28), .N(LT + LR)) u_dly_alt (
        .i_clk(i_clk), .i_en(en), .i_d(i_alt_mm), .o_d(alt_d)
    );
    assign alt20 = {{16{alt_d[27]}}, alt_d, 20'd0};
    gte_delay #(.W(64), .N(gte_pkg::LAT_MUL)) u_dly_alt20 (
        .i_clk(i_clk), .i_en(en), .i_d(alt20), .o_d(alt20_d)
    );

    logic [63:0] cp_d, cl_d, sl_d, sp_d;
    logic [2:0]  neg_d;
    gte_delay #(.W(64), .N(LR + 1)) u_dly_cp (
        .i_clk(i_clk), .i_en(en), .i_d(lat_tr.cos_mag), .o_d(cp_d)
    );
    gte_delay #(.W(192), .N(LR + 1 + gte_pkg::LAT_MUL)) u_dly_trig (
        .i_clk(i_clk), .i_en(en),
        .i_d({lon_tr.cos_mag, lon_tr.sin_mag, lat_tr.sin_mag}),
        .o_d({cl_d, sl_d, sp_d})
    );
    gte_delay #(.W(3), .N(LR + 1 + 2 * gte_pkg::LAT_MUL)) u_dly_neg (
        .i_clk(i_clk), .i_en(en),
        .i_d({lat_tr.cos_neg ^ lon_tr.cos_neg, lat_tr.cos_neg ^ lon_tr.sin_neg,
              lat_tr.sin_neg}),
        .o_d(neg_d)
    );

    // Heights: N + alt for x and y, (1-f)^2 N + alt for z.
    logic [63:0]  r_h, r_hz;
    logic [127:0] p_bn, p_hcp, p_x, p_y, p_z;

    gte_mul64 u_mul_bn (
        .i_clk(i_clk), .i_en(en), .i_a(n20), .i_b(gte_pkg::BSQ_Q62), .o_p(p_bn)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h  <= n20 + alt20;
            r_hz <= p_bn[125:62] + alt20_d;
        end
    end

    gte_mul64 u_mul_hcp (.i_clk(i_clk), .i_en(en), .i_a(r_h), .i_b(cp_d), .o_p(p_hcp));
    gte_mul64 u_mul_x (.i_clk(i_clk), .i_en(en), .i_a(p_hcp[125:62]), .i_b(cl_d), .o_p(p_x));
    gte_mul64 u_mul_y (.i_clk(i_clk), .i_en(en), .i_a(p_hcp[125:62]), .i_b(sl_d), .o_p(p_y));
    gte_mul64 u_mul_z (.i_clk(i_clk), .i_en(en), .i_a(r_hz), .i_b(sp_d), .o_p(p_z));

    // Round Q20 to whole mm, half away from zero, then apply the sign.
    logic [63:0] sum_x, sum_y, sum_z;
    logic [33:0] mm_x, mm_y, mm_z, res_x, res_y, res_z;

    always_comb begin
        sum_x = p_x[125:62] + 64'h8_0000;
        sum_y = p_y[125:62] + 64'h8_0000;
        sum_z = p_z[125:62] + 64'h8_0000;
        mm_x  = sum_x[53:20];
        mm_y  = sum_y[53:20];
        mm_z  = sum_z[53:20];
        res_x = neg_d[2] ? ~mm_x + 34'd1 : mm_x;
        res_y = neg_d[1] ? ~mm_y + 34'd1 : mm_y;
        res_z = neg_d[0] ? ~mm_z + 34'd1 : mm_z;
    end

    // Two-entry output queue.
    logic [33:0] r_fx [0:1];
    logic [33:0] r_fy [0:1];
    logic [33:0] r_fz [0:1];

    assign push = en && r_vld[LAT_PIPE-1];
    assign pop  = o_valid && !i_stall;

    always_comb begin
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fx[r_wp] <= res_x;
            r_fy[r_wp] <= res_y;
            r_fz[r_wp] <= res_z;
        end
    end

    assign o_valid     = (r_cnt != 2'd0);
    assign o_ecef_x_mm = r_fx[r_rp];
    assign o_ecef_y_mm = r_fy[r_rp];
    assign o_ecef_z_mm = r_fz[r_rp];

    a_cnt_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("output queue count out of range");

    a_ptr_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp ^ r_rp) == r_cnt[0])
        else $error("output queue pointers disagree with count");

    a_push_cnt : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("output queue count missed a push");

    a_pop_cnt : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("output queue count missed a pop");

endmodule

// ----- tb/tb_geodetic_to_ecef.sv -----
// Self-checking testbench for the geodetic to ECEF converter.
// Depends on the geodetic_to_ecef RTL only; holds its own bit-true predictor.
module tb_geodetic_to_ecef;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LATENCY    = 215;
    localparam int          WATCHDOG   = 4000;
    localparam int          N_RANDOM   = 850;
    localparam int          CALM_TAIL  = 120;
    localparam logic [63:0] Q62_ONE    = 64'h4000_0000_0000_0000;
    localparam longint      TURN       = 64'sd3600000000;
    localparam longint      QUARTER    = 64'sd900000000;
    localparam longint      EIGHTH     = 64'sd450000000;

    typedef struct packed {
        logic [33:0] x;
        logic [33:0] y;
        logic [33:0] z;
    } t_ecef;

    // One directed row: position plus optional typed-in result.
    typedef struct {
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        logic signed [27:0] alt;
        bit                 known;
        t_ecef              want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [30:0] i_lat_e7 = '0;
    logic signed [31:0] i_lon_e7 = '0;
    logic signed [27:0] i_alt_mm = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [33:0] o_ecef_x_mm;
    logic signed [33:0] o_ecef_y_mm;
    logic signed [33:0] o_ecef_z_mm;

    geodetic_to_ecef DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_ecef  pending_fixes[$];
    t_row   rows[$];
    int     n_errors = 0;
    int     idle_cycles = 0;
    bit     calm = 1'b0;

    // Ellipsoid constants in Q62 and angle scale in Q93, as the arithmetic defines them.
    logic [63:0] flat_q62, ecc2_q62, polar_q62, k_q93;

    function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return 64'(p >> 62);
    endfunction

    // Sine and cosine of an angle in [0, 45] degrees, truncated Taylor series.
    task automatic octant_sincos(input logic [63:0] t, output logic [63:0] s,
                                 output logic [63:0] c);
        logic [63:0] t2, st, ct;
        t2 = q62_mul(t, t);
        st = t;
        ct = Q62_ONE;
        s  = t;
        c  = Q62_ONE;
        for (int k = 1; k <= 13; k++) begin
            ct = q62_mul(ct, t2) / 64'((2 * k - 1) * (2 * k));
            st = q62_mul(st, t2) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                c = c - ct;
                s = s - st;
            end else begin
                c = c + ct;
                s = s + st;
            end
        end
    endtask

    // Reduce exactly modulo a full turn, fold to an octant, then unfold by quadrant.
    task automatic angle_sincos(input longint ang, output logic [63:0] sm, output bit sn,
                                output logic [63:0] cm, output bit cn);
        longint      m, quad, r;
        logic [63:0] t, s0, c0;
        logic [127:0] p;
        m = ang % TURN;
        if (m < 0)
            m += TURN;
        quad = m / QUARTER;
        r    = m - quad * QUARTER;
        if (r > EIGHTH) begin
            p = 128'(QUARTER - r) * 128'(k_q93);
            t = 64'(p >> 31);
            octant_sincos(t, c0, s0);
        end else begin
            p = 128'(r) * 128'(k_q93);
            t = 64'(p >> 31);
            octant_sincos(t, s0, c0);
        end
        case (quad)
            0: begin sm = s0; sn = 0; cm = c0; cn = 0; end
            1: begin sm = c0; sn = 0; cm = s0; cn = 1; end
            2: begin sm = s0; sn = 1; cm = c0; cn = 1; end
            default: begin sm = c0; sn = 1; cm = s0; cn = 0; end
        endcase
    endtask

    function automatic logic [33:0] round_mm(logic [63:0] mag_q20, bit neg);
        logic [63:0] mm;
        mm = (mag_q20 + 64'(1 << 19)) >> 20;
        if (neg)
            mm = -mm;
        return mm[33:0];
    endfunction

    task automatic predict_ecef(input logic signed [30:0] lat, input logic signed [31:0] lon,
                                input logic signed [27:0] alt, output t_ecef fix);
        logic [63:0]  sp, cp, sl, cl, w, root, n20, h, hz, alt20, hc;
        bit           spn, cpn, sln, cln;
        logic [127:0] rad, c;
        angle_sincos(longint'(lat), sp, spn, cp, cpn);
        angle_sincos(longint'(lon), sl, sln, cl, cln);
        w   = Q62_ONE - q62_mul(ecc2_q62, q62_mul(sp, sp));
        rad = 128'(w) << 62;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            c = 128'(root | (64'd1 << i));
            if (c * c <= rad)
                root = c[63:0];
        end
        n20   = 64'((128'd6378137000 << 82) / 128'(root));
        alt20 = 64'(longint'(alt)) << 20;
        h     = n20 + alt20;
        hz    = q62_mul(n20, polar_q62) + alt20;
        hc    = q62_mul(h, cp);
        fix.x = round_mm(q62_mul(hc, cl), cpn != cln);
        fix.y = round_mm(q62_mul(hc, sl), cpn != sln);
        fix.z = round_mm(q62_mul(hz, sp), spn);
    endtask

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("mismatch %s at %0t", what, $realtime);
    endtask

    // Sink side: random stall bursts, none begun in the calm tail.
    initial begin
        int burst;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 9);
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
        end
    end

    // Check every result taken against the oldest expected fix.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_ecef want;
            if (pending_fixes.size() == 0) begin
                report_mismatch("unexpected result");
            end else begin
                want = pending_fixes.pop_front();
                if (o_ecef_x_mm !== want.x)
                    report_mismatch($sformatf("x: got %0d want %0d", o_ecef_x_mm,
                                              $signed(want.x)));
                if (o_ecef_y_mm !== want.y)
                    report_mismatch($sformatf("y: got %0d want %0d", o_ecef_y_mm,
                                              $signed(want.y)));
                if (o_ecef_z_mm !== want.z)
                    report_mismatch($sformatf("z: got %0d want %0d", o_ecef_z_mm,
                                              $signed(want.z)));
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Present one request after an optional gap, hold it until taken, leave valid high.
    task automatic send_position(input logic signed [30:0] lat, input logic signed [31:0] lon,
                                 input logic signed [27:0] alt, input bit known,
                                 input t_ecef want);
        t_ecef fix;
        int    gap;
        if (!calm && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 9);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_lat_e7 <= lat;
        i_lon_e7 <= lon;
        i_alt_mm <= alt;
        @(posedge i_clk iff !o_stall);
        predict_ecef(lat, lon, alt, fix);
        if (known && fix !== want)
            report_mismatch($sformatf("predictor against typed-in fix, lat %0d lon %0d",
                                      lat, lon));
        pending_fixes = {pending_fixes, fix};
    endtask

    function automatic t_ecef ecef_of(longint x, longint y, longint z);
        t_ecef e;
        e.x = x[33:0];
        e.y = y[33:0];
        e.z = z[33:0];
        return e;
    endfunction

    function automatic void add_row(longint lat, longint lon, longint alt, bit known,
                                    t_ecef want);
        t_row row;
        row.lat   = 31'(lat);
        row.lon   = 32'(lon);
        row.alt   = 28'(alt);
        row.known = known;
        row.want  = want;
        rows = {rows, row};
    endfunction

    initial begin
        t_ecef none;
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        logic signed [27:0] alt;
        int sel;
        none = '0;

        flat_q62  = 64'((128'd1000000000 << 62) / 128'd298257223563);
        ecc2_q62  = (flat_q62 << 1) - q62_mul(flat_q62, flat_q62);
        polar_q62 = q62_mul(Q62_ONE - flat_q62, Q62_ONE - flat_q62);
        k_q93     = 64'(((128'h3243F6A8885A308D313198A2E0370734) / 128'd1800000000) >> 31);

        // Equator points read off the ellipsoid; poles and the rest via the predictor.
        add_row(0, 0, 0, 1'b1, ecef_of(64'sd6378137000, 0, 0));
        add_row(0, 900000000, 0, 1'b1, ecef_of(0, 64'sd6378137000, 0));
        add_row(0, 1800000000, 0, 1'b1, ecef_of(-64'sd6378137000, 0, 0));
        add_row(0, -900000000, 0, 1'b1, ecef_of(0, -64'sd6378137000, 0));
        add_row(900000000, 0, 0, 1'b0, none);
        add_row(-900000000, 0, 0, 1'b0, none);
        add_row(450000000, 450000000, 0, 1'b0, none);
        add_row(450000001, 449999999, 12345, 1'b0, none);
        add_row(-450000000, -1350000000, -10000000, 1'b0, none);
        add_row(0, 0, 28'sh7FFFFFF, 1'b0, none);
        add_row(0, 0, 28'sh8000000, 1'b0, none);
        add_row(31'sh3FFFFFFF, 32'sh7FFFFFFF, 100000000, 1'b0, none);
        add_row(31'sh40000000, 32'sh80000000, 28'sh8000000, 1'b0, none);
        add_row(-1, -1, -1, 1'b0, none);
        add_row(1, 1, 1, 1'b0, none);
        add_row(900000001, 1800000001, 0, 1'b0, none);
        add_row(-900000001, -1800000001, 0, 1'b0, none);
        add_row(1350000000, 64'sd2700000000, 500, 1'b0, none);
        add_row(377777777, 1234567890, 8848000, 1'b0, none);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_position(rows[i].lat, rows[i].lon, rows[i].alt, rows[i].known, rows[i].want);

        // Hold off the sender until every directed fix is back.
        i_valid <= 1'b0;
        wait (pending_fixes.size() == 0);
        @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= N_RANDOM - CALM_TAIL);
            sel  = $urandom_range(0, 9);
            if (sel < 6) begin
                // Normal positions: lat +-90, lon +-180 degrees, height -10 to 100 km.
                lat = 31'($signed($urandom_range(0, 1800000000)) - 900000000);
                lon = 32'($signed($urandom % 32'd3600000001) - 64'sd1800000000);
                alt = 28'($signed($urandom_range(0, 110000000)) - 10000000);
            end else if (sel < 8) begin
                // Full raw bit patterns, out-of-range angles included.
                lat = 31'($urandom);
                lon = 32'($urandom);
                alt = 28'($urandom);
            end else begin
                // Near octant and quadrant boundaries.
                lat = 31'($signed($urandom_range(0, 8)) * 450000000 - 1800000000
                           + $signed($urandom_range(0, 4)) - 2);
                lon = 32'($signed($urandom_range(0, 8)) * 450000000 - 1800000000
                           + $signed($urandom_range(0, 4)) - 2);
                alt = 28'($signed($urandom_range(0, 20000)) - 10000);
            end
            send_position(lat, lon, alt, 0, none);
        end
        i_valid <= 1'b0;

        wait (pending_fixes.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
